// File: rtl/lidar_response_frame_parser_core_macros.svh
// Assertion macros shared by the lidar response frame parser RTL.
`ifndef LIDAR_RESPONSE_FRAME_PARSER_CORE_MACROS_SVH
`define LIDAR_RESPONSE_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high
`define LRFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high
`define LRFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lrfp_pkg.sv
// Types and constants for the lidar response frame parser.
package lrfp_pkg;

  // Framing bytes
  localparam logic [7:0] SYNC_BYTE  = 8'h02;
  localparam logic [7:0] SUB_FIRST  = 8'h12;
  localparam logic [7:0] SUB_SECOND = 8'h23;
  localparam logic [7:0] END_BYTE   = 8'h03;

  // Command types
  localparam logic [7:0] CMD_SET   = 8'd1;
  localparam logic [7:0] CMD_GET   = 8'd2;
  localparam logic [7:0] CMD_OTHER = 8'd3;
  localparam logic [7:0] CMD_BUSY  = 8'd4;

  // Codes
  localparam logic [7:0] CODE_ALL    = 8'd0;
  localparam logic [7:0] CODE_BULK_A = 8'd13;
  localparam logic [7:0] CODE_BULK_B = 8'd14;
  localparam logic [7:0] CODE_BULK_C = 8'd31;
  localparam logic [7:0] CODE_BULK_D = 8'd32;

  // Frames in a bulk transaction
  localparam logic [5:0] BULK_FRAMES = 6'd42;
  localparam logic [5:0] COUNT_MAX   = 6'd63;

  // Byte offsets from the first subheader byte
  localparam logic [3:0] OFS_AFTER_SUB = 4'd1;
  localparam logic [3:0] OFS_CMD       = 4'd4;
  localparam logic [3:0] OFS_CODE      = 4'd5;
  localparam logic [3:0] OFS_DATA_LO   = 4'd6;
  localparam logic [3:0] OFS_DATA_HI   = 4'd9;
  localparam logic [3:0] OFS_END       = 4'd11;
  localparam logic [3:0] OFS_MAX       = 4'd15;

  localparam logic [2:0] SYNC_OPEN = 3'd4;
  localparam logic [2:0] SYNC_MAX  = 3'd7;

  // Register map
  localparam logic REG_CMD  = 1'b0;
  localparam logic REG_CODE = 1'b1;

  // Result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_WRONG = 2'd2
  } status_t;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HDR  = 3'b001,
    PH_SUB  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

endpackage

// File: rtl/lidar_response_frame_parser_core.sv
// Path: a byte that gives a result passes through the input register, then the result register.
// Throughput: one byte per cycle; while a result waits downstream, bytes keep being taken
// until the next byte that gives a result sits in the input register.
// Only a byte that gives a result needs the result register; other bytes never stall.
// Reset (rst, synchronous): parser hunts for a header, frame count zero, both
// registers read 1, input and result registers empty.
`include "lidar_response_frame_parser_core_macros.svh"

module lidar_response_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] new_request
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] frame_data, [37:32] frame_index, [39:38] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast,   // transaction_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [7:0] exp_cmd;
  logic [7:0] exp_code;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_new;

  // parser state
  lrfp_pkg::phase_t phase, phase_next;
  logic [2:0]  sync_run, sync_run_next;
  logic        first_sub, first_sub_next;
  logic [3:0]  byte_offset, byte_offset_next;
  logic [31:0] data_shift, data_shift_next;
  logic [5:0]  frame_count, frame_count_next;

  // result
  logic              res_valid;
  lrfp_pkg::status_t res_status;
  logic [31:0]       res_data;
  logic [5:0]        res_index;
  logic              res_done;

  logic        advance;
  logic [2:0]  sync_inc;
  logic [3:0]  ofs_inc;
  logic [5:0]  count_inc;
  logic        is_sync;
  logic        all_codes;
  logic        no_target;
  logic        bulk_target;
  logic        cfg_write;

  // APB port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == lrfp_pkg::REG_CODE) ? {24'd0, exp_code} : {24'd0, exp_cmd};

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_cmd  <= lrfp_pkg::CMD_SET;
      exp_code <= 8'd1;
    end else if (cfg_write) begin
      if (paddr[2] == lrfp_pkg::REG_CODE) begin
        exp_code <= pwdata[7:0];
      end else begin
        exp_cmd <= pwdata[7:0];
      end
    end
  end

  // target frame count from the request
  assign all_codes   = (exp_cmd == lrfp_pkg::CMD_GET) && (exp_code == lrfp_pkg::CODE_ALL);
  assign no_target   = !((exp_cmd == lrfp_pkg::CMD_SET) || (exp_cmd == lrfp_pkg::CMD_OTHER))
                       && (exp_code == lrfp_pkg::CODE_ALL);
  assign bulk_target = !((exp_cmd == lrfp_pkg::CMD_SET) || (exp_cmd == lrfp_pkg::CMD_OTHER))
                       && ((exp_code == lrfp_pkg::CODE_BULK_A) ||
                           (exp_code == lrfp_pkg::CODE_BULK_B) ||
                           (exp_code == lrfp_pkg::CODE_BULK_C) ||
                           (exp_code == lrfp_pkg::CODE_BULK_D));

  // saturating increments
  assign is_sync   = (in_byte == lrfp_pkg::SYNC_BYTE);
  assign sync_inc  = (sync_run == lrfp_pkg::SYNC_MAX) ? sync_run : sync_run + 3'd1;
  assign ofs_inc   = (byte_offset == lrfp_pkg::OFS_MAX) ? byte_offset : byte_offset + 4'd1;
  assign count_inc = (frame_count == lrfp_pkg::COUNT_MAX) ? frame_count : frame_count + 6'd1;

  // per-byte parse step
  always_comb begin
    phase_next       = phase;
    sync_run_next    = sync_run;
    first_sub_next   = first_sub;
    byte_offset_next = byte_offset;
    data_shift_next  = data_shift;
    frame_count_next = frame_count;
    res_valid        = 1'b0;
    res_status       = lrfp_pkg::ST_OK;
    res_data         = 32'd0;
    res_index        = 6'd0;
    res_done         = 1'b0;

    if (in_new) begin
      phase_next       = lrfp_pkg::PH_HDR;
      sync_run_next    = 3'd0;
      first_sub_next   = 1'b0;
      byte_offset_next = 4'd0;
      data_shift_next  = 32'd0;
      frame_count_next = 6'd0;
    end else begin
      sync_run_next = is_sync ? sync_inc : 3'd0;
      priority if (is_sync && (sync_inc == lrfp_pkg::SYNC_OPEN) &&
                   (phase == lrfp_pkg::PH_HDR)) begin
        // header opens a frame
        phase_next       = lrfp_pkg::PH_SUB;
        first_sub_next   = 1'b0;
        byte_offset_next = 4'd0;
      end else if (phase == lrfp_pkg::PH_HDR) begin
        // still hunting for a header
      end else if (phase == lrfp_pkg::PH_SUB) begin
        if (first_sub && (in_byte == lrfp_pkg::SUB_SECOND)) begin
          first_sub_next   = 1'b0;
          phase_next       = lrfp_pkg::PH_BODY;
          byte_offset_next = lrfp_pkg::OFS_AFTER_SUB;
        end else begin
          first_sub_next = (in_byte == lrfp_pkg::SUB_FIRST);
        end
      end else begin
        // fixed-offset body
        byte_offset_next = ofs_inc;
        if (ofs_inc == lrfp_pkg::OFS_CMD) begin
          if (in_byte == lrfp_pkg::CMD_BUSY) begin
            res_valid  = 1'b1;
            res_status = lrfp_pkg::ST_BUSY;
          end else if (in_byte != exp_cmd) begin
            res_valid  = 1'b1;
            res_status = lrfp_pkg::ST_WRONG;
          end
        end else if (ofs_inc == lrfp_pkg::OFS_CODE) begin
          if (in_byte == lrfp_pkg::CODE_ALL) begin
            res_valid  = 1'b1;
            res_status = lrfp_pkg::ST_BUSY;
          end else if ((in_byte != exp_code) && !all_codes) begin
            res_valid  = 1'b1;
            res_status = lrfp_pkg::ST_WRONG;
          end
        end else if ((ofs_inc >= lrfp_pkg::OFS_DATA_LO) && (ofs_inc <= lrfp_pkg::OFS_DATA_HI)) begin
          data_shift_next = {in_byte, data_shift[31:8]};
        end else if (ofs_inc == lrfp_pkg::OFS_END) begin
          res_valid = 1'b1;
          if (in_byte != lrfp_pkg::END_BYTE) begin
            res_status = lrfp_pkg::ST_WRONG;
          end else begin
            res_data         = data_shift;
            res_index        = frame_count;
            frame_count_next = count_inc;
            res_done         = !no_target &&
                               (!bulk_target || (count_inc >= lrfp_pkg::BULK_FRAMES));
            phase_next       = lrfp_pkg::PH_HDR;
            first_sub_next   = 1'b0;
            byte_offset_next = 4'd0;
          end
        end

        // any error clears the parser, frame count kept
        if (res_valid && (res_status != lrfp_pkg::ST_OK)) begin
          phase_next       = lrfp_pkg::PH_HDR;
          sync_run_next    = 3'd0;
          first_sub_next   = 1'b0;
          byte_offset_next = 4'd0;
          data_shift_next  = 32'd0;
        end
      end
    end
  end

  // a word moves on unless it has a result and the result register is full and stalled
  assign advance  = in_valid && (!res_valid || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_new  <= s_tuser;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lrfp_pkg::PH_HDR;
      sync_run    <= 3'd0;
      first_sub   <= 1'b0;
      byte_offset <= 4'd0;
      data_shift  <= 32'd0;
      frame_count <= 6'd0;
    end else if (advance) begin
      phase       <= phase_next;
      sync_run    <= sync_run_next;
      first_sub   <= first_sub_next;
      byte_offset <= byte_offset_next;
      data_shift  <= data_shift_next;
      frame_count <= frame_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_tdata <= {2'b00, res_index, res_data};
      m_tuser <= res_status;
      m_tlast <= res_done;
    end
  end

  // checks
  `LRFP_ASSERT_NOW(a_err_payload_zero, m_tvalid && (m_tuser != lrfp_pkg::ST_OK),
    (m_tdata == 40'd0) && !m_tlast, "error result carries payload")
  `LRFP_ASSERT_NOW(a_body_offset_range, phase == lrfp_pkg::PH_BODY,
    (byte_offset >= lrfp_pkg::OFS_AFTER_SUB) && (byte_offset <= lrfp_pkg::OFS_END),
    "body offset out of frame")
  `LRFP_ASSERT_NEXT(a_new_request_clears, advance && in_new,
    (frame_count == 6'd0) && (phase == lrfp_pkg::PH_HDR), "new request did not clear")
  `LRFP_ASSERT_NEXT(a_result_loaded, advance && res_valid,
    m_tvalid, "result lost")

endmodule
